// File: design/cflg_pkg.sv
// Shared constants, register codes and control types for the candle flicker level generator.
package cflg_pkg;

  localparam int unsigned LfsrW = 32;
  localparam int unsigned HalfW = 7;

  localparam logic [LfsrW-1:0] FbMask    = 32'hA3AC183C;
  localparam logic [LfsrW-1:0] SeedReset = 32'd1;
  localparam logic [LfsrW-1:0] SeedZeroSub = 32'd1;

  localparam logic [7:0] WindLowReset  = 8'd70;
  localparam logic [7:0] WindHighReset = 8'd92;
  localparam logic [7:0] WindReseed    = 8'd255;
  localparam logic [7:0] LevelMax      = 8'd255;
  localparam logic [7:0] NormalBias    = 8'h80;

  typedef enum logic [1:0] {
    REG_SEED      = 2'd0,
    REG_WIND_LOW  = 2'd1,
    REG_WIND_HIGH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic step;
  } lfsr_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
  } ser_ctl_t;

endpackage

// File: design/cflg_lfsr.sv
// Galois LFSR giving one random bit per step.
module cflg_lfsr (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cflg_pkg::lfsr_ctl_t      ctl_i,
  input  logic [cflg_pkg::LfsrW-1:0] seed_i,
  output logic                     bit_o
);
  import cflg_pkg::*;

  logic [LfsrW-1:0] state_q, state_d, next_s;

  assign next_s = {1'b0, state_q[LfsrW-1:1]} ^ (state_q[0] ? FbMask : '0);
  // The drawn bit is the low bit after the step.
  assign bit_o  = next_s[0];

  always_comb begin
    state_d = state_q;
    if (ctl_i.load) begin
      state_d = seed_i;
    end else if (ctl_i.step) begin
      state_d = next_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeedReset;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/cflg_mod.sv
// Bit-serial remainder: takes the dividend MSB first, one bit per cycle while stepped.
module cflg_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cflg_pkg::ser_ctl_t ctl_i,
  input  logic               bit_i,
  input  logic [7:0]         span_i,
  output logic [7:0]         rem_o
);
  import cflg_pkg::*;

  logic [7:0] rem_q, rem_d;
  logic [8:0] shifted;

  assign shifted = {rem_q, bit_i};
  assign rem_o   = rem_q;

  always_comb begin
    rem_d = rem_q;
    if (ctl_i.start) begin
      rem_d = '0;
    end else if (ctl_i.step) begin
      // shifted stays below twice the span, so one subtract suffices
      if (shifted >= {1'b0, span_i}) begin
        rem_d = 8'(shifted - {1'b0, span_i});
      end else begin
        rem_d = shifted[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

// File: design/cflg_mul.sv
// Shift-and-add multiplier: unsigned half-wind times signed normal, one bit per cycle while stepped.
module cflg_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cflg_pkg::ser_ctl_t          ctl_i,
  input  logic [cflg_pkg::HalfW-1:0]  mplier_i,
  input  logic [7:0]                  mcand_i,
  output logic [15:0]                 prod_o
);
  import cflg_pkg::*;

  logic [HalfW-1:0] mplier_q, mplier_d;
  logic [7:0]       mcand_q, mcand_d;
  logic [15:0]      prod_q, prod_d;
  logic [15:0]      addend;

  assign addend = mplier_q[HalfW-1] ? {{8{mcand_q[7]}}, mcand_q} : 16'd0;
  assign prod_o = prod_q;

  always_comb begin
    mplier_d = mplier_q;
    mcand_d  = mcand_q;
    prod_d   = prod_q;
    if (ctl_i.start) begin
      mplier_d = mplier_i;
      mcand_d  = mcand_i;
      prod_d   = '0;
    end else if (ctl_i.step) begin
      // MSB first: double, then add
      prod_d   = {prod_q[14:0], 1'b0} + addend;
      mplier_d = {mplier_q[HalfW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mplier_q <= '0;
      mcand_q  <= '0;
      prod_q   <= '0;
    end else begin
      mplier_q <= mplier_d;
      mcand_q  <= mcand_d;
      prod_q   <= prod_d;
    end
  end

endmodule

// File: design/candle_flicker_level_generator_top.sv
// Top level: sequencer, state registers, fade logic and output register.
// A tick's result waits while an earlier result is held in the output register.
// Throughput: one tick at a time; the serial LFSR (32 bits drawn one per cycle),
//   the serial remainder and the serial multiplier do the work of a frame-start tick.
// A new tick is taken while an earlier result still waits in the output register.
// Reset is asynchronous, active low; the first tick after reset reseeds.
module candle_flicker_level_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        reseed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  duty_o,
  output logic        frame_end_o
);
  import cflg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MOD   = 9'b000000010,
    S_WIND  = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_LEFT  = 9'b000010000,
    S_RIGHT = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_LEVEL = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [LfsrW-1:0] seed_q;
  logic [7:0] wind_low_q, wind_high_q;

  logic [3:0] cnt_q, cnt_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] wind_q, wind_d;
  logic [7:0] from_q, from_d;
  logic [7:0] to_q, to_d;
  logic [1:0] phase_q, phase_d;
  logic       started_q, started_d;
  logic       reseed_q, reseed_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] duty_q, duty_d;
  logic       fend_q, fend_d;

  lfsr_ctl_t lfsr_ctl;
  ser_ctl_t  mod_ctl, mul_ctl;
  logic       rnd_bit;
  logic [7:0] rem;
  logic [15:0] prod;
  logic [LfsrW-1:0] seed_eff;

  logic [7:0]  span, target;
  logic [9:0]  wind_sum;
  logic [3:0]  weight;
  logic [7:0]  term;
  logic [7:0]  base;
  logic [10:0] level_x;
  logic [7:0]  level;
  logic [8:0]  diff;
  logic [7:0]  q4;
  logic [7:0]  fade_duty;
  logic        fade_end;
  logic        out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedReset;
      wind_low_q  <= WindLowReset;
      wind_high_q <= WindHighReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SEED:      seed_q      <= cfg_data_i;
        REG_WIND_LOW:  wind_low_q  <= cfg_data_i[7:0];
        REG_WIND_HIGH: wind_high_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign seed_eff = (seed_q == '0) ? SeedZeroSub : seed_q;
  assign span     = (wind_high_q > wind_low_q) ? 8'(wind_high_q - wind_low_q) : 8'd1;
  assign target   = 8'(wind_low_q + rem);
  // (64*w + 192*t) >> 8 is (w + 3t) >> 2
  assign wind_sum = {2'b00, wind_q} + {2'b00, target} + {1'b0, target, 1'b0};

  assign weight = 4'b1000 >> cnt_q[1:0];
  assign term   = {4'b0000, weight & {4{rnd_bit}}};

  assign base    = 8'(LevelMax - wind_q);
  assign level_x = $signed({3'b000, base}) + $signed(prod[15:5]);
  always_comb begin
    if (level_x[10]) begin
      level = '0;
    end else if (level_x[9:8] != 2'b00) begin
      level = LevelMax;
    end else begin
      level = level_x[7:0];
    end
  end

  // Fade between the two targets in quarter steps
  assign diff = {1'b0, to_q} - {1'b0, from_q};
  assign q4   = {diff[8], diff[8:2]};
  always_comb begin
    fade_end = 1'b0;
    case (phase_q)
      2'd0:    fade_duty = 8'(from_q + q4);
      2'd1:    fade_duty = 8'(from_q + diff[8:1]);
      2'd2:    fade_duty = 8'(to_q - q4);
      default: begin
        fade_duty = to_q;
        fade_end  = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    wind_d      = wind_q;
    from_d      = from_q;
    to_d        = to_q;
    phase_d     = phase_q;
    started_d   = started_q;
    reseed_d    = reseed_q;
    out_valid_d = out_valid_q && out_stall_i;
    duty_d      = duty_q;
    fend_d      = fend_q;
    lfsr_ctl    = '0;
    mod_ctl     = '0;
    mul_ctl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          if (reseed_i || !started_q) begin
            lfsr_ctl.load = 1'b1;
            wind_d    = WindReseed;
            phase_d   = '0;
            started_d = 1'b1;
            reseed_d  = 1'b1;
            acc_d     = NormalBias;
            state_d   = S_SUM;
          end else begin
            reseed_d = 1'b0;
            if (phase_q == 2'd0) begin
              mod_ctl.start = 1'b1;
              state_d       = S_MOD;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_MOD: begin
        lfsr_ctl.step = 1'b1;
        mod_ctl.step  = 1'b1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          state_d = S_WIND;
        end
      end
      S_WIND: begin
        wind_d  = wind_sum[9:2];
        acc_d   = NormalBias;
        cnt_d   = '0;
        state_d = S_SUM;
      end
      S_SUM: begin
        lfsr_ctl.step = 1'b1;
        acc_d = acc_q + {3'b000, rnd_bit, 4'b0000};
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          cnt_d   = '0;
          state_d = S_LEFT;
        end
      end
      S_LEFT: begin
        lfsr_ctl.step = 1'b1;
        acc_d = acc_q + term;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          cnt_d   = '0;
          state_d = S_RIGHT;
        end
      end
      S_RIGHT: begin
        lfsr_ctl.step = 1'b1;
        acc_d = acc_q - term;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          // hand the finished normal straight to the multiplier
          mul_ctl.start = 1'b1;
          cnt_d   = '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        mul_ctl.step = 1'b1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(HalfW - 1)) begin
          state_d = S_LEVEL;
        end
      end
      S_LEVEL: begin
        if (reseed_q) begin
          from_d = level;
        end else begin
          from_d = to_q;
        end
        to_d    = level;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (reseed_q) begin
            duty_d = to_q;
            fend_d = 1'b1;
          end else begin
            duty_d  = fade_duty;
            fend_d  = fade_end;
            phase_d = phase_q + 2'd1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wind_q      <= WindReseed;
      from_q      <= '0;
      to_q        <= '0;
      phase_q     <= '0;
      started_q   <= 1'b0;
      reseed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wind_q      <= wind_d;
      from_q      <= from_d;
      to_q        <= to_d;
      phase_q     <= phase_d;
      started_q   <= started_d;
      reseed_q    <= reseed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    duty_q <= duty_d;
    fend_q <= fend_d;
  end

  cflg_lfsr u_lfsr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lfsr_ctl),
    .seed_i (seed_eff),
    .bit_o  (rnd_bit)
  );

  cflg_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mod_ctl),
    .bit_i  (rnd_bit),
    .span_i (span),
    .rem_o  (rem)
  );

  cflg_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mul_ctl),
    .mplier_i (wind_q[7:1]),
    .mcand_i  (acc_d),
    .prod_o   (prod)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign frame_end_o = fend_q;

endmodule

// File: design/cflg_checker.sv
// Port-level checks on the top level, bound to it.
module cflg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        reseed_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  duty_o,
  input logic        frame_end_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(duty_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // An accepted item keeps the block busy in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken on consecutive cycles");

  // A reseed into an empty output stage gives a frame-end result
  a_reseed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && reseed_i && !out_valid_o
    |-> ##34 (out_valid_o && frame_end_o))
    else $error("reseed result missing or late");

endmodule

bind candle_flicker_level_generator_top cflg_checker u_cflg_checker (.*);
